>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, quiet while reset is held.
`define TED_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define TED_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ted_pkg.sv
`default_nettype none

package ted_pkg;

  // Ring geometry (power-of-two frame count and frame length)
  localparam int MAX_DELAY_FRAMES = 64;
  localparam int FRAME_MAX        = 1024;
  localparam int FRAME_W          = $clog2(MAX_DELAY_FRAMES);
  localparam int POS_W            = $clog2(FRAME_MAX);
  localparam int ADDR_W           = FRAME_W + POS_W;
  localparam int HIST_DEPTH       = MAX_DELAY_FRAMES * FRAME_MAX;
  localparam int RP_W             = FRAME_W + 16;
  localparam int RPX_W            = RP_W + 3;

  // Field and register widths
  localparam int SAMPLE_W = 24;
  localparam int BLUR_W   = 17;
  localparam int GAIN_W   = 16;
  localparam int DLY_W    = 14;
  localparam int FSIZE_W  = 11;
  localparam int CFG_W    = 17;
  localparam int IDX_W    = 3;

  // Register reset values
  localparam int BLUR_RST  = 0;
  localparam int FBG_RST   = 32768;
  localparam int DRY_RST   = 23170;
  localparam int WET_RST   = 23170;
  localparam int DLY_RST   = 2560;
  localparam int WOW_RST   = 0;
  localparam int ALPHA_RST = 65529;
  localparam int FSIZE_RST = 512;

  // Clamp limits and coefficients
  localparam int BLUR_MAX   = 65536;
  localparam int FBG_MAX    = 65339;
  localparam int GAIN_MAX   = 32768;
  localparam int DLY_MIN    = 256;
  localparam int DLY_MAX    = (MAX_DELAY_FRAMES - 2) * 256;
  localparam int ALPHA_MAX  = 65529;
  localparam int G_COEF     = 11796;
  localparam int DEPTH_COEF = 26214;
  localparam int AP_MIN     = 7;
  localparam int SAT_MIN    = 66;
  localparam int DRIVE_ONE  = 65536;
  localparam int TAB_TOP    = 16;

  localparam int SAMPLE_MAX = 8388607;
  localparam int SAMPLE_MIN = -8388608;

  // Shared multiplier: signed A x signed B, registered product
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = 47;
  localparam int ACC_W   = 48;

  // Divider for the saturation gain compensation
  localparam int DIV_STEPS = 23;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int REM_W     = 18;

  localparam logic [15:0] SINE_Q [17] = '{
    16'd0, 16'd3212, 16'd6393, 16'd9512, 16'd12539, 16'd15446, 16'd18205,
    16'd20787, 16'd23170, 16'd25329, 16'd27245, 16'd28898, 16'd30273,
    16'd31356, 16'd32137, 16'd32609, 16'd32767
  };

  localparam logic [15:0] TANH_Q [17] = '{
    16'd0, 16'd8150, 16'd16051, 16'd23485, 16'd30286, 16'd36346, 16'd41625,
    16'd46131, 16'd49912, 16'd53038, 16'd55593, 16'd57660, 16'd59320,
    16'd60644, 16'd61694, 16'd62524, 16'd63179
  };

  typedef enum logic [IDX_W-1:0] {
    REG_BLUR, REG_FEEDBACK, REG_DRY, REG_WET,
    REG_DELAY, REG_WOW, REG_ALPHA, REG_FRAME_SIZE
  } reg_idx_t;

  typedef enum logic [3:0] {
    MU_NONE, MU_BB, MU_G, MU_DEPTH, MU_SIN, MU_OFF, MU_INT, MU_LP,
    MU_AP1, MU_AP2, MU_DRV, MU_TANH, MU_FB, MU_DRY, MU_WET
  } mul_sel_t;

  typedef enum logic [4:0] {
    TK_NONE, TK_B2, TK_G, TK_DEPTH, TK_SINV, TK_RP, TK_A0, TK_A1, TK_DLY,
    TK_LP, TK_AP1, TK_AP2, TK_U, TK_T, TK_Q, TK_WB, TK_ACC, TK_Y
  } take_t;

  typedef enum logic [5:0] {
    ST_CLEAR, ST_IDLE, ST_BYP, ST_B2M, ST_B2T, ST_GM, ST_GT, ST_WOW,
    ST_DEPT, ST_SINM, ST_SINT, ST_OFFM, ST_OFFT, ST_RD0, ST_RD1, ST_RD2,
    ST_INTM, ST_INTT, ST_LPM, ST_LPT, ST_AP1M, ST_AP1T, ST_AP2M, ST_AP2T,
    ST_DRVM, ST_UT, ST_TNM, ST_TNT, ST_DIV, ST_DIVT, ST_FBM, ST_WBT,
    ST_DRYM, ST_WETM, ST_YT, ST_DONE
  } state_t;

  typedef struct packed {
    mul_sel_t mul;
    take_t    take;
    logic     load_x;
    logic     mem_re;
    logic     rd_next;
    logic     wow_step;
    logic     div_step;
    logic     out_load;
    logic     out_byp;
    logic     clear_step;
  } cmd_t;

  typedef struct packed {
    logic wet_zero;
    logic pos_zero;
    logic ap_on;
    logic sat_on;
    logic div_last;
    logic clear_last;
    logic out_free;
    logic frame_wr;
  } status_t;

  // Round to nearest, halves up, then arithmetic shift
  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                   input int unsigned s);
    logic signed [ACC_W-1:0] half;
    half = ACC_W'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(SAMPLE_MAX)) return SAMPLE_W'(SAMPLE_MAX);
    if (v < ACC_W'(SAMPLE_MIN)) return SAMPLE_W'(SAMPLE_MIN);
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [15:0] sine_base(input logic [4:0] idx);
    return (idx >= 5'(TAB_TOP)) ? SINE_Q[TAB_TOP] : SINE_Q[idx];
  endfunction

  function automatic logic [15:0] sine_step(input logic [4:0] idx);
    return (idx >= 5'(TAB_TOP)) ? 16'd0 : SINE_Q[idx + 5'd1] - SINE_Q[idx];
  endfunction

  function automatic logic [15:0] tanh_base(input logic [4:0] idx);
    return (idx >= 5'(TAB_TOP)) ? TANH_Q[TAB_TOP] : TANH_Q[idx];
  endfunction

  function automatic logic [15:0] tanh_step(input logic [4:0] idx);
    return (idx >= 5'(TAB_TOP)) ? 16'd0 : TANH_Q[idx + 5'd1] - TANH_Q[idx];
  endfunction

endpackage

`default_nettype wire

>>> design/ted_ctrl.sv
`default_nettype none

module ted_ctrl import ted_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (st.frame_wr) begin
      state_next = ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: if (st.clear_last) state_next = ST_IDLE;
        ST_IDLE: begin
          if (in_valid) state_next = st.wet_zero ? ST_BYP : ST_B2M;
        end
        ST_BYP:  if (st.out_free) state_next = ST_IDLE;
        ST_B2M:  state_next = ST_B2T;
        ST_B2T:  state_next = ST_GM;
        ST_GM:   state_next = ST_GT;
        ST_GT:   state_next = st.pos_zero ? ST_WOW : ST_RD0;
        ST_WOW:  state_next = ST_DEPT;
        ST_DEPT: state_next = ST_SINM;
        ST_SINM: state_next = ST_SINT;
        ST_SINT: state_next = ST_OFFM;
        ST_OFFM: state_next = ST_OFFT;
        ST_OFFT: state_next = ST_RD0;
        ST_RD0:  state_next = ST_RD1;
        ST_RD1:  state_next = ST_RD2;
        ST_RD2:  state_next = ST_INTM;
        ST_INTM: state_next = ST_INTT;
        ST_INTT: state_next = ST_LPM;
        ST_LPM:  state_next = ST_LPT;
        ST_LPT: begin
          priority if (st.ap_on) state_next = ST_AP1M;
          else if (st.sat_on)    state_next = ST_DRVM;
          else                   state_next = ST_FBM;
        end
        ST_AP1M: state_next = ST_AP1T;
        ST_AP1T: state_next = ST_AP2M;
        ST_AP2M: state_next = ST_AP2T;
        ST_AP2T: state_next = st.sat_on ? ST_DRVM : ST_FBM;
        ST_DRVM: state_next = ST_UT;
        ST_UT:   state_next = ST_TNM;
        ST_TNM:  state_next = ST_TNT;
        ST_TNT:  state_next = ST_DIV;
        ST_DIV:  if (st.div_last) state_next = ST_DIVT;
        ST_DIVT: state_next = ST_FBM;
        ST_FBM:  state_next = ST_WBT;
        ST_WBT:  state_next = ST_DRYM;
        ST_DRYM: state_next = ST_WETM;
        ST_WETM: state_next = ST_YT;
        ST_YT:   state_next = ST_DONE;
        ST_DONE: if (st.out_free) state_next = ST_IDLE;
        default: state_next = ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.load_x = in_valid;
      end
      ST_BYP:  cmd.out_byp = st.out_free;
      ST_B2M:  cmd.mul = MU_BB;
      ST_B2T:  cmd.take = TK_B2;
      ST_GM:   cmd.mul = MU_G;
      ST_GT:   cmd.take = TK_G;
      ST_WOW: begin
        cmd.wow_step = 1'b1;
        cmd.mul      = MU_DEPTH;
      end
      ST_DEPT: cmd.take = TK_DEPTH;
      ST_SINM: cmd.mul = MU_SIN;
      ST_SINT: cmd.take = TK_SINV;
      ST_OFFM: cmd.mul = MU_OFF;
      ST_OFFT: cmd.take = TK_RP;
      ST_RD0:  cmd.mem_re = 1'b1;
      ST_RD1: begin
        cmd.mem_re  = 1'b1;
        cmd.rd_next = 1'b1;
        cmd.take    = TK_A0;
      end
      ST_RD2:  cmd.take = TK_A1;
      ST_INTM: cmd.mul = MU_INT;
      ST_INTT: cmd.take = TK_DLY;
      ST_LPM:  cmd.mul = MU_LP;
      ST_LPT:  cmd.take = TK_LP;
      ST_AP1M: cmd.mul = MU_AP1;
      ST_AP1T: cmd.take = TK_AP1;
      ST_AP2M: cmd.mul = MU_AP2;
      ST_AP2T: cmd.take = TK_AP2;
      ST_DRVM: cmd.mul = MU_DRV;
      ST_UT:   cmd.take = TK_U;
      ST_TNM:  cmd.mul = MU_TANH;
      ST_TNT:  cmd.take = TK_T;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DIVT: cmd.take = TK_Q;
      ST_FBM:  cmd.mul = MU_FB;
      ST_WBT:  cmd.take = TK_WB;
      ST_DRYM: cmd.mul = MU_DRY;
      ST_WETM: begin
        cmd.take = TK_ACC;
        cmd.mul  = MU_WET;
      end
      ST_YT:   cmd.take = TK_Y;
      ST_DONE: cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/ted_dp.sv
`default_nettype none

module ted_dp import ted_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [IDX_W-1:0]           cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_data,
  input  wire logic signed [SAMPLE_W-1:0] in_data,
  input  wire logic                       out_ready,
  input  wire cmd_t                       cmd,
  output status_t                         st,
  output logic                            out_valid,
  output logic signed [SAMPLE_W-1:0]      out_data,
  output logic                            out_last
);

  // Configuration
  logic [BLUR_W-1:0]  blur;
  logic [GAIN_W-1:0]  fbg, dry, wet, wow_inc, alpha;
  logic [DLY_W-1:0]   dly;
  logic [FSIZE_W-1:0] fsize;

  // Long-lived state
  logic [FRAME_W-1:0]         wr_frame, rd_frame;
  logic [POS_W-1:0]           pos;
  logic [15:0]                wow, rd_frac;
  logic signed [SAMPLE_W-1:0] lp, ap;
  logic [ADDR_W-1:0]          clr_cnt;

  // Per-item working registers
  logic signed [SAMPLE_W-1:0] x, a0, a1, delayed, fb, ap_tmp, y;
  logic [BLUR_W-1:0]          b2;
  logic [13:0]                g;
  logic [14:0]                depth;
  logic signed [16:0]         sinv;
  logic                       u_neg;
  logic [24:0]                mag;
  logic [REM_W-1:0]           rem;
  logic [DIV_STEPS-1:0]       low, q;
  logic [DIV_CNT_W-1:0]       dcnt;
  logic signed [PROD_W-1:0]   p, acc;
  logic signed [SAMPLE_W-1:0] rdata;
  logic [SAMPLE_W-1:0]        mem [HIST_DEPTH];

  // Clamped settings
  logic [BLUR_W-1:0]  b_c;
  logic [GAIN_W-1:0]  fbg_c, dg_c, wg_c, alpha_c;
  logic [DLY_W-1:0]   d_c;
  logic [FSIZE_W-1:0] fs_c;
  logic [POS_W-1:0]   pos_e;
  logic [17:0]        drive;

  assign b_c     = (blur > BLUR_W'(BLUR_MAX)) ? BLUR_W'(BLUR_MAX) : blur;
  assign fbg_c   = (fbg > GAIN_W'(FBG_MAX)) ? GAIN_W'(FBG_MAX) : fbg;
  assign dg_c    = (dry > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : dry;
  assign wg_c    = (wet > GAIN_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX) : wet;
  assign alpha_c = (alpha > GAIN_W'(ALPHA_MAX)) ? GAIN_W'(ALPHA_MAX) : alpha;
  assign d_c     = (dly < DLY_W'(DLY_MIN)) ? DLY_W'(DLY_MIN) :
                   (dly > DLY_W'(DLY_MAX)) ? DLY_W'(DLY_MAX) : dly;
  assign fs_c    = (fsize == '0) ? FSIZE_W'(1) :
                   (fsize > FSIZE_W'(FRAME_MAX)) ? FSIZE_W'(FRAME_MAX) : fsize;
  assign pos_e   = (FSIZE_W'(pos) >= fs_c) ? '0 : pos;
  assign drive   = 18'(DRIVE_ONE) + 18'(b2);

  logic frame_wr;
  assign frame_wr = cfg_we && (cfg_index == REG_FRAME_SIZE);

  // Wow sine lookup
  logic [14:0] sine_w;
  logic [4:0]  sidx;
  logic [15:0] sbase, sdiff, s_mag;
  assign sine_w = wow[14] ? 15'h4000 - {1'b0, wow[13:0]} : {1'b0, wow[13:0]};
  assign sidx   = sine_w[14:10];
  assign sbase  = sine_base(sidx);
  assign sdiff  = sine_step(sidx);

  // tanh lookup on the saturation input magnitude
  logic [4:0]  tidx;
  logic [15:0] tbase, tdiff, t_val;
  assign tidx  = mag[24:20];
  assign tbase = tanh_base(tidx);
  assign tdiff = tanh_step(tidx);

  // Shared multiplier operand select
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul)
      MU_NONE:  ;
      MU_BB:    begin mul_a = MUL_A_W'(b_c);      mul_b = MUL_B_W'(b_c);            end
      MU_G:     begin mul_a = MUL_A_W'(b_c);      mul_b = MUL_B_W'(G_COEF);         end
      MU_DEPTH: begin mul_a = MUL_A_W'(b2);       mul_b = MUL_B_W'(DEPTH_COEF);     end
      MU_SIN:   begin mul_a = MUL_A_W'(sdiff);    mul_b = MUL_B_W'(sine_w[9:0]);    end
      MU_OFF:   begin mul_a = MUL_A_W'(sinv);     mul_b = MUL_B_W'(depth);          end
      MU_INT:   begin mul_a = MUL_A_W'(a1) - MUL_A_W'(a0); mul_b = MUL_B_W'(rd_frac); end
      MU_LP:    begin mul_a = MUL_A_W'(delayed) - MUL_A_W'(lp); mul_b = MUL_B_W'(alpha_c); end
      MU_AP1:   begin mul_a = MUL_A_W'(fb);       mul_b = MUL_B_W'(g);              end
      MU_AP2:   begin mul_a = MUL_A_W'(ap_tmp);   mul_b = MUL_B_W'(g);              end
      MU_DRV:   begin mul_a = MUL_A_W'(fb);       mul_b = MUL_B_W'(drive);          end
      MU_TANH:  begin mul_a = MUL_A_W'(tdiff);    mul_b = MUL_B_W'(mag[19:0]);      end
      MU_FB:    begin mul_a = MUL_A_W'(fb);       mul_b = MUL_B_W'(fbg_c);          end
      MU_DRY:   begin mul_a = MUL_A_W'(x);        mul_b = MUL_B_W'(dg_c);           end
      MU_WET:   begin mul_a = MUL_A_W'(delayed);  mul_b = MUL_B_W'(wg_c);           end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul != MU_NONE) p <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Product consumers
  logic signed [ACC_W-1:0]   p_x, r16, r15, s_rnd, t_rnd, y_sum;
  logic signed [RPX_W-1:0]   rp_full;
  logic signed [SAMPLE_W-1:0] lp_new, wb_val;
  logic signed [25:0]        u_full;
  logic [REM_W:0]            r2;

  assign p_x    = ACC_W'(p);
  assign r16    = rnd(p_x, 16);
  assign r15    = rnd(p_x, 15);
  assign s_rnd  = rnd(p_x, 10);
  assign t_rnd  = rnd(p_x, 20);
  assign y_sum  = rnd(ACC_W'(acc) + p_x, 15);
  assign s_mag  = sbase + 16'(s_rnd);
  assign t_val  = tbase + 16'(t_rnd);
  // Wow offset is signed; keep its sign through the wrap of the read point
  assign rp_full = RPX_W'({wr_frame, 16'h0000}) - RPX_W'({d_c, 8'h00}) - RPX_W'(r15);
  assign lp_new = sat24(ACC_W'(lp) + r16);
  assign wb_val = sat24(ACC_W'(x) + r16);
  assign u_full = r16[25:0];
  assign r2     = {rem, low[DIV_STEPS-1]};

  always_ff @(posedge clk) begin
    unique case (cmd.take)
      TK_NONE:  ;
      TK_B2:    b2 <= p[32:16];
      TK_G:     g <= p[29:16];
      TK_DEPTH: depth <= p[30:16];
      TK_SINV:  sinv <= wow[15] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
      TK_A0:    a0 <= rdata;
      TK_A1:    a1 <= rdata;
      TK_DLY:   delayed <= SAMPLE_W'(ACC_W'(a0) + r16);
      TK_AP1:   ap_tmp <= sat24(ACC_W'(ap) - r16);
      TK_U: begin
        u_neg <= u_full[25];
        mag   <= u_full[25] ? 25'(-u_full) : u_full[24:0];
      end
      TK_T: begin
        rem  <= REM_W'(t_val);
        low  <= DIV_STEPS'(drive >> 1);
        dcnt <= '0;
      end
      TK_ACC:   acc <= p;
      TK_Y:     y <= sat24(y_sum);
      default:  ;
    endcase
    if (cmd.load_x) x <= in_data;
    if (cmd.div_step) begin
      // Restoring division, one quotient bit per cycle
      if (r2 >= (REM_W + 1)'(drive)) begin
        rem <= REM_W'(r2 - (REM_W + 1)'(drive));
        q   <= {q[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= REM_W'(r2);
        q   <= {q[DIV_STEPS-2:0], 1'b0};
      end
      low  <= low << 1;
      dcnt <= dcnt + 1'b1;
    end
  end

  // Fractional delay memory, one write and one registered read per cycle
  logic              mem_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [SAMPLE_W-1:0] wdata;

  assign mem_we = cmd.clear_step || (cmd.take == TK_WB);
  assign waddr  = cmd.clear_step ? clr_cnt : {wr_frame, pos_e};
  assign wdata  = cmd.clear_step ? '0 : wb_val;
  assign raddr  = {cmd.rd_next ? rd_frame + 1'b1 : rd_frame, pos_e};

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (cmd.mem_re) rdata <= mem[raddr];
  end

  // Configuration, filter state and frame bookkeeping
  logic [FSIZE_W-1:0] pos_inc;
  assign pos_inc = FSIZE_W'(pos_e) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blur      <= BLUR_W'(BLUR_RST);
      fbg       <= GAIN_W'(FBG_RST);
      dry       <= GAIN_W'(DRY_RST);
      wet       <= GAIN_W'(WET_RST);
      dly       <= DLY_W'(DLY_RST);
      wow_inc   <= GAIN_W'(WOW_RST);
      alpha     <= GAIN_W'(ALPHA_RST);
      fsize     <= FSIZE_W'(FSIZE_RST);
      wr_frame  <= '0;
      rd_frame  <= '0;
      rd_frac   <= '0;
      pos       <= '0;
      wow       <= '0;
      lp        <= '0;
      ap        <= '0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else if (frame_wr) begin
      fsize    <= cfg_data[FSIZE_W-1:0];
      wr_frame <= '0;
      rd_frame <= '0;
      rd_frac  <= '0;
      pos      <= '0;
      wow      <= '0;
      lp       <= '0;
      ap       <= '0;
      clr_cnt  <= '0;
      if (out_ready) out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_BLUR:       blur    <= cfg_data[BLUR_W-1:0];
          REG_FEEDBACK:   fbg     <= cfg_data[GAIN_W-1:0];
          REG_DRY:        dry     <= cfg_data[GAIN_W-1:0];
          REG_WET:        wet     <= cfg_data[GAIN_W-1:0];
          REG_DELAY:      dly     <= cfg_data[DLY_W-1:0];
          REG_WOW:        wow_inc <= cfg_data[GAIN_W-1:0];
          REG_ALPHA:      alpha   <= cfg_data[GAIN_W-1:0];
          REG_FRAME_SIZE: fsize   <= cfg_data[FSIZE_W-1:0];
          default:        ;
        endcase
      end
      if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.wow_step) wow <= wow + wow_inc;
      if (cmd.take == TK_RP) begin
        rd_frame <= rp_full[RP_W-1:16];
        rd_frac  <= rp_full[15:0];
      end
      if (cmd.take == TK_LP) begin
        lp <= lp_new;
        fb <= lp_new;
      end
      if (cmd.take == TK_AP2) begin
        ap <= sat24(ACC_W'(fb) + r16);
        fb <= ap_tmp;
      end
      if (cmd.take == TK_Q) fb <= u_neg ? -SAMPLE_W'(q) : SAMPLE_W'(q);
      // Output register: drop on take, load on a finished item
      if (cmd.out_load || cmd.out_byp) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.out_byp) begin
        out_data <= x;
        out_last <= 1'b0;
      end
      if (cmd.out_load) begin
        out_data <= y;
        if (pos_inc >= fs_c) begin
          pos      <= '0;
          out_last <= 1'b1;
          wr_frame <= wr_frame + 1'b1;
        end else begin
          pos      <= pos_inc[POS_W-1:0];
          out_last <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    st.wet_zero   = (wet == '0);
    st.pos_zero   = (pos_e == '0);
    st.ap_on      = (g >= 14'(AP_MIN));
    st.sat_on     = (b2 >= BLUR_W'(SAT_MIN));
    st.div_last   = (dcnt == DIV_CNT_W'(DIV_STEPS - 1));
    st.clear_last = (&clr_cnt);
    st.out_free   = !out_valid || out_ready;
    st.frame_wr   = frame_wr;
  end

endmodule

`default_nettype wire

>>> design/tape_echo_frame_delay.sv
// Each sample is sequenced through the controller's states; the first sample of
//   a frame adds the wow and read-point steps, and active allpass and saturation
//   add their own. Samples go one at a time through the single shared multiplier
//   and the 23-step divider that scales the saturator output. A bypassed sample
//   (wet gain zero) is registered, then copied to the output register when free.
// Reset (and any frame_size write) runs a pass that zeroes all 65536 words of
//   the history memory; s_axis_tready stays low until it completes.
`default_nettype none

module tape_echo_frame_delay import ted_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [23:0]        s_axis_tdata,   // [23:0] in_sample
  // Output stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [23:0]             m_axis_tdata,   // [23:0] out_sample
  output logic                    m_axis_tlast,   // frame_end
  // Configuration write port
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  // Controller sequences one sample at a time through the datapath's shared
  // multiplier; the datapath owns the settings, filter state and history ring.
  cmd_t    cmd;
  status_t st;
  logic signed [SAMPLE_W-1:0] out_data;

  ted_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ted_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   ($signed(s_axis_tdata)),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data),
    .out_last  (m_axis_tlast)
  );

  // Hold the result in the output register until the transaction completes
  assign m_axis_tdata = out_data;

endmodule

`default_nettype wire

>>> design/ted_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ted_checker import ted_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [23:0]      m_axis_tdata,
  input wire logic             m_axis_tlast,
  input wire logic             cfg_we,
  input wire logic [IDX_W-1:0] cfg_index
);

  // One sample in flight: after a transaction the input side closes
  `TED_ASSERT(a_one_in_flight, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted while busy")

  // Frame size write starts the history clear
  `TED_ASSERT(a_fsize_clears, clk, rst, cfg_we && (cfg_index == REG_FRAME_SIZE) |=> !s_axis_tready, "no clear after frame size write")

  // Reset starts the clear pass and empties the output register
  `TED_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !s_axis_tready && !m_axis_tvalid, "reset did not clear")

  // Stalled result holds
  `TED_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind tape_echo_frame_delay ted_checker u_ted_checker (.*);

`default_nettype wire
